>>> design/mrlt_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the mesh route learning table
// no dependencies

package mrlt_pkg;

  localparam int MAC_W           = 48;
  localparam int DEFAULT_ENTRIES = 16;
  localparam int OP_W            = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LEARN  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_FORGET = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_COMPARE = 3'b010,
    ST_APPLY   = 3'b100
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic compare;
    logic apply;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

>>> design/mrlt_ctrl.sv
`timescale 1ns / 1ps
// controller for the route table: sequences load, compare and apply
// depends on mrlt_pkg

module mrlt_ctrl
  import mrlt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.compare = 1'b0;
    cmd.apply   = 1'b0;
    in_ready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        cmd.compare = 1'b1;
        state_next  = ST_APPLY;
      end
      ST_APPLY: begin
        // hold until the output register can take the result
        if (!sts.out_busy) begin
          cmd.apply  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/mrlt_datapath.sv
`timescale 1ns / 1ps
// datapath: input register, entry cells with parallel compare, update logic,
// output register. depends on mrlt_pkg
module mrlt_datapath
  import mrlt_pkg::*;
#(
  parameter int ENTRIES = DEFAULT_ENTRIES
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [OP_W-1:0]  in_op,
  input  logic [MAC_W-1:0] in_dest,
  input  logic [MAC_W-1:0] in_hop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_found,
  output logic [MAC_W-1:0] out_next_hop,
  output logic             out_status
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  op_t              op_q;
  logic [MAC_W-1:0] dest_q;
  logic [MAC_W-1:0] hop_q;

  logic [ENTRIES-1:0] entry_valid;
  logic [MAC_W-1:0]   entry_dest [ENTRIES];
  logic [MAC_W-1:0]   entry_hop  [ENTRIES];

  logic [ENTRIES-1:0] match_q;
  logic [ENTRIES-1:0] match_next;

  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] free_idx;
  logic             any_match;
  logic             any_free;
  logic             do_insert;
  logic             res_found;
  logic [MAC_W-1:0] res_next_hop;
  logic             res_status;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op_t'(in_op);
      dest_q <= in_dest;
      hop_q  <= in_hop;
    end
  end

  // one comparator per entry
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_next[i] = entry_valid[i] && (entry_dest[i] == dest_q);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      match_q <= match_next;
    end
  end

  // lowest matching slot and lowest free slot
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!entry_valid[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign any_match = |match_q;
  assign any_free  = ~&entry_valid;
  assign do_insert = (op_q == OP_LEARN) && !any_match && (dest_q != hop_q) && any_free;

  always_comb begin
    res_found    = 1'b0;
    res_next_hop = '0;
    res_status   = 1'b0;
    unique case (op_q)
      OP_LEARN: begin
        res_found  = any_match;
        res_status = !any_match && (dest_q != hop_q) && !any_free;
      end
      OP_LOOKUP: begin
        res_found    = any_match;
        res_next_hop = any_match ? entry_hop[hit_idx] : dest_q;
      end
      OP_FORGET: begin
        res_found = any_match;
      end
      default: begin
        res_found = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.apply) begin
      if (op_q == OP_FORGET) begin
        entry_valid <= entry_valid & ~match_q;
      end else if (do_insert) begin
        entry_valid[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && (op_q == OP_LEARN)) begin
      if (any_match) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (match_q[i]) begin
            entry_hop[i] <= hop_q;
          end
        end
      end else if (do_insert) begin
        entry_dest[free_idx] <= dest_q;
        entry_hop[free_idx]  <= hop_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.apply) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_found    <= res_found;
      out_next_hop <= res_next_hop;
      out_status   <= res_status;
    end
  end

  assign sts.out_busy = out_valid && !out_ready;

endmodule

>>> design/mesh_route_learning_table_core.sv
`timescale 1ns / 1ps
// mesh route learning table: maps a destination node address to its next hop
// input beat on s_axis: operation in tuser, destination and neighbour in tdata
// result beat on m_axis: next hop in tdata, found and full flags in tuser
// one item at a time: an accepted beat is registered, compared against every
// valid entry in parallel in the next cycle, and the table update plus the
// result register load follow once the result register is free
// a new item is taken only after the previous one has passed the compare
// register and update stage
// s_axis_tready is high only while no item is in flight; a new item can be
// taken while the previous result still waits on m_axis
// when m_axis stalls, the result register holds and the next item waits in
// its update stage until the register is free
// reset clears all valid bits (table empty) and drops any pending result;
// stored addresses are not cleared
// depends on mrlt_pkg, mrlt_ctrl, mrlt_datapath

module mesh_route_learning_table_core
  import mrlt_pkg::*;
#(
  parameter int ENTRIES = DEFAULT_ENTRIES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [2*MAC_W-1:0]   s_axis_tdata,   // dest_mac, hop_mac
  input  logic [OP_W-1:0]      s_axis_tuser,   // operation
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [MAC_W-1:0]     m_axis_tdata,   // next_hop
  output logic [1:0]           m_axis_tuser    // found, status
);

  cmd_t cmd;
  sts_t sts;

  mrlt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mrlt_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_op        (s_axis_tuser),
    .in_dest      (s_axis_tdata[MAC_W-1:0]),
    .in_hop       (s_axis_tdata[2*MAC_W-1:MAC_W]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_found    (m_axis_tuser[0]),
    .out_next_hop (m_axis_tdata),
    .out_status   (m_axis_tuser[1])
  );

endmodule

>>> design/mrlt_checker.sv
`timescale 1ns / 1ps
// port-level checks for the route table core, bound to the top level
// depends on mrlt_pkg and mesh_route_learning_table_core

module mrlt_checker
  import mrlt_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [MAC_W-1:0]   m_axis_tdata,
  input logic [1:0]         m_axis_tuser
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // an accepted item blocks the input for its compare and update cycles
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input taken while an item is in flight");

  // a result never appears the cycle after an accept
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result arrived too early");

  // the full flag only accompanies a beat without a match and with a zero next hop
  a_full_no_hit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0] && (m_axis_tdata == '0))
    else $error("full flag on a matching result");

endmodule

bind mesh_route_learning_table_core mrlt_checker u_mrlt_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
